### hw/rtl/tks_pkg.sv
`timescale 1ns / 1ps
package tks_pkg;

   localparam int unsigned KMaxDefault   = 64;
   localparam int unsigned RowMaxDefault = 65536;
   localparam int unsigned ValueWidth    = 32;
   localparam int unsigned IndexWidth    = 16;
   localparam int unsigned KeepWidth     = 7;

   typedef enum logic [0:0] {
      CSR_KEEP_COUNT   = 1'b0,
      CSR_PICK_LARGEST = 1'b1
   } csr_index_type;

   typedef enum logic [0:0] {
      ST_COLLECT = 1'b0,
      ST_EMIT    = 1'b1
   } state_type;

   typedef struct packed {
      logic [ValueWidth-1:0] value_in;
      logic                  last_in;
   } req_payload_type;

   typedef struct packed {
      logic [ValueWidth-1:0] value_out;
      logic [IndexWidth-1:0] index_out;
      logic                  last_out;
      logic                  row_overflow;
   } rsp_payload_type;

   // One chain entry.
   typedef struct packed {
      logic                  valid;
      logic [ValueWidth-1:0] value;
      logic [IndexWidth-1:0] index;
   } entry_type;

   // Control broadcast to every cell.
   typedef struct packed {
      logic insert;
      logic shift_out;
      logic clear;
      logic pick_largest;
   } cell_ctrl_type;

   // Map float bits to an unsigned key in numeric order; -0 folds onto +0.
   function automatic logic [ValueWidth-1:0] order_key(input logic [ValueWidth-1:0] b);
      logic [ValueWidth-1:0] t;
      t = (b[ValueWidth-2:0] == '0) ? '0 : b;
      return t[ValueWidth-1] ? ~t : (t | {1'b1, {(ValueWidth-1){1'b0}}});
   endfunction

endpackage

### hw/rtl/tks_cell.sv
`timescale 1ns / 1ps
module tks_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  tks_pkg::cell_ctrl_type ctrl,
   input  tks_pkg::entry_type     new_entry,
   input  logic [31:0]            new_key,
   input  tks_pkg::entry_type     prev_entry,
   input  logic                   prev_take,
   input  tks_pkg::entry_type     next_entry,
   output tks_pkg::entry_type     entry,
   output logic                   take
);
   import tks_pkg::*;

   entry_type   entry_ff, entry_in;
   logic [31:0] held_key;
   logic        better;
   logic        hit;

   assign held_key = order_key(entry_ff.value);
   assign better   = ctrl.pick_largest ? (new_key > held_key) : (new_key < held_key);
   assign hit      = !entry_ff.valid || better;
   // New item lands here or above: every cell from the first hit on shifts down,
   // even when a mid-row order change leaves the held entries unsorted.
   assign take     = hit || prev_take;

   always_comb begin
      entry_in = entry_ff;
      priority if (ctrl.clear) begin
         entry_in.valid = 1'b0;
      end else if (ctrl.shift_out) begin
         entry_in = next_entry;
      end else if (ctrl.insert && take) begin
         entry_in = prev_take ? prev_entry : new_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
      entry_ff.value <= entry_in.value;
      entry_ff.index <= entry_in.index;
   end

   assign entry = entry_ff;
endmodule

### hw/rtl/top_k_select.sv
`timescale 1ns / 1ps
// Channel | Ports                                    | Transfer when
// req     | start, busy, req_payload                 | start && !busy
// rsp     | rsp_strobe, rsp_payload                  | rsp_strobe (one cycle)
// csr     | csr_valid, csr_ready, csr_index, csr_data| csr_valid && csr_ready
//
// Each element enters the cell chain as it is accepted; the chain compares and
// shifts every cell in parallel. On the last element of a row of n elements
// the block shifts the chain head out as min(k, n) results, busy high
// throughout, then is ready again.
// Synchronous active-high reset empties the chain and sets k=1, largest.
// The receiver cannot stall; results leave one per cycle from a register.
module top_k_select #(
   parameter int unsigned K_MAX   = tks_pkg::KMaxDefault,
   parameter int unsigned ROW_MAX = tks_pkg::RowMaxDefault
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  tks_pkg::req_payload_type req_payload,
   output logic                     rsp_strobe,
   output tks_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [0:0]               csr_index,
   input  logic [31:0]              csr_data
);
   import tks_pkg::*;

   localparam int unsigned PosWidth = $clog2(ROW_MAX + 1);

   state_type state_ff, state_in;
   logic [KeepWidth-1:0] keep_ff, keep_in;
   logic                 pick_ff, pick_in;
   logic [PosWidth-1:0]  pos_ff, pos_in;
   logic                 ovf_ff, ovf_in;
   logic [KeepWidth-1:0] left_ff, left_in;   // one more than results still to send
   logic                 strobe_ff, strobe_in;
   rsp_payload_type      rsp_ff, rsp_in;

   logic          accept;
   logic          stop_now;
   cell_ctrl_type ctrl;
   entry_type     new_entry;
   logic [31:0]   new_key;
   entry_type     cells  [K_MAX];
   logic          takes  [K_MAX];
   entry_type     empty_entry;
   logic [KeepWidth-1:0] k_eff;

   assign accept    = start && !busy;
   assign busy      = (state_ff == ST_EMIT);
   assign csr_ready = 1'b1;

   // Position tag, saturated past the row limit.
   always_comb begin
      pos_in = pos_ff;
      ovf_in = ovf_ff;
      new_entry.valid = 1'b1;
      new_entry.value = req_payload.value_in;
      if (pos_ff >= PosWidth'(ROW_MAX)) begin
         new_entry.index = IndexWidth'(ROW_MAX - 1);
         if (accept) ovf_in = 1'b1;
      end else begin
         new_entry.index = IndexWidth'(pos_ff);
         if (accept) pos_in = pos_ff + 1'b1;
      end
      if (state_ff == ST_EMIT && left_ff == KeepWidth'(1)) begin
         pos_in = '0;
         ovf_in = 1'b0;
      end
   end
   assign new_key = order_key(req_payload.value_in);

   assign empty_entry = '0;
   assign ctrl.insert       = accept;
   assign ctrl.shift_out    = (state_ff == ST_EMIT);
   assign ctrl.clear        = (state_ff == ST_EMIT) && stop_now;
   assign ctrl.pick_largest = pick_ff;

   for (genvar i = 0; i < K_MAX; i++) begin : g_cell
      tks_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .new_entry  (new_entry),
         .new_key    (new_key),
         .prev_entry ((i == 0) ? empty_entry : cells[(i == 0) ? 0 : i-1]),
         .prev_take  ((i == 0) ? 1'b0 : takes[(i == 0) ? 0 : i-1]),
         .next_entry ((i == K_MAX-1) ? empty_entry : cells[(i == K_MAX-1) ? i : i+1]),
         .entry      (cells[i]),
         .take       (takes[i])
      );
   end

   // Clamp k to 1..K_MAX.
   always_comb begin
      if (keep_ff == '0) k_eff = KeepWidth'(1);
      else if (keep_ff > KeepWidth'(K_MAX)) k_eff = KeepWidth'(K_MAX);
      else k_eff = keep_ff;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_COLLECT: if (accept && req_payload.last_in) state_in = ST_EMIT;
         ST_EMIT:    if (left_ff == KeepWidth'(1)) state_in = ST_COLLECT;
         default:    state_in = ST_COLLECT;
      endcase
   end

   // Outputs and counters. Count of results is fixed on the cycle after
   // the last element lands: min(k, valid cells) results are sent, the head first.
   logic [KeepWidth-1:0] valid_cnt;
   always_comb begin
      valid_cnt = '0;
      for (int i = 0; i < K_MAX; i++) begin
         if (cells[i].valid) valid_cnt = KeepWidth'(i + 1);
      end
   end

   logic first_ff, first_in;
   always_comb begin
      left_in   = left_ff;
      first_in  = 1'b0;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      if (accept && req_payload.last_in) first_in = 1'b1;
      if (state_ff == ST_EMIT) begin
         if (first_ff) begin
            left_in = (valid_cnt < k_eff) ? valid_cnt : k_eff;
         end else begin
            left_in = left_ff - 1'b1;
         end
      end
      // Head of chain goes out while shifting.
      if (state_ff == ST_EMIT) begin
         strobe_in          = 1'b1;
         rsp_in.value_out    = cells[0].value;
         rsp_in.index_out    = cells[0].index;
         rsp_in.row_overflow = ovf_ff;
         rsp_in.last_out     = first_ff ? ((valid_cnt < k_eff ? valid_cnt : k_eff)
                                           == KeepWidth'(1)) : (left_ff == KeepWidth'(2));
      end
   end

   // The emit state ends on the cycle that sends the last result, when left_ff reads two;
   // on the first emit cycle left_ff is not yet loaded, so derive the stop from the count.
   assign stop_now = first_ff ? ((valid_cnt < k_eff ? valid_cnt : k_eff) == KeepWidth'(1))
                              : (left_ff == KeepWidth'(2));

   // CSR writes.
   always_comb begin
      keep_in = keep_ff;
      pick_in = pick_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_KEEP_COUNT:   keep_in = csr_data[KeepWidth-1:0];
            CSR_PICK_LARGEST: pick_in = csr_data[0];
            default:          keep_in = keep_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_COLLECT;
         keep_ff   <= KeepWidth'(1);
         pick_ff   <= 1'b1;
         pos_ff    <= '0;
         ovf_ff    <= 1'b0;
         left_ff   <= '0;
         strobe_ff <= 1'b0;
         first_ff  <= 1'b0;
      end else begin
         keep_ff   <= keep_in;
         pick_ff   <= pick_in;
         strobe_ff <= strobe_in;
         first_ff  <= first_in;
         // Stop shifting on the last result: go back to collect, reset row.
         if (state_ff == ST_EMIT && stop_now) begin
            state_ff <= ST_COLLECT;
            left_ff  <= '0;
            pos_ff   <= '0;
            ovf_ff   <= 1'b0;
         end else begin
            state_ff <= (state_in == ST_EMIT) ? ST_EMIT : state_ff;
            left_ff  <= left_in;
            pos_ff   <= pos_in;
            ovf_ff   <= ovf_in;
         end
      end
      rsp_ff <= rsp_in;
   end

   // Remaining chain entries are dropped on the final emit cycle, through
   // the clear control, so the next row starts with an empty chain.
   assign rsp_strobe  = strobe_ff;
   assign rsp_payload = rsp_ff;
endmodule

### hw/rtl/top_k_select_checker.sv
`timescale 1ns / 1ps
module top_k_select_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     start,
   input logic                     busy,
   input tks_pkg::req_payload_type req_payload,
   input logic                     rsp_strobe,
   input tks_pkg::rsp_payload_type rsp_payload
);
   import tks_pkg::*;

   a_idle_no_rsp: assert property (@(posedge clock) disable iff (reset)
      !busy && !$past(busy) |-> !rsp_strobe) else $error("result while idle");

   a_last_starts: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_payload.last_in |=> busy) else $error("no emit after last");

   a_plain_no_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && !req_payload.last_in |=> !busy) else $error("busy without last");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_payload.last_out |=> !rsp_strobe) else $error("result after last");
endmodule

bind top_k_select top_k_select_checker u_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .req_payload(req_payload), .rsp_strobe(rsp_strobe), .rsp_payload(rsp_payload)
);

### dv/tb_top_k_select.sv
`timescale 1ns / 1ps
module tb_top_k_select;
   import tks_pkg::*;

   localparam int KCells   = 64;
   localparam int RowLimit = 65536;
   localparam int Stall    = 4000;   // cycles with no transfer before giving up

   logic            clock;
   logic            reset;
   logic            start;
   logic            busy;
   req_payload_type req_payload;
   logic            rsp_strobe;
   rsp_payload_type rsp_payload;
   logic            csr_valid;
   logic            csr_ready;
   logic [0:0]      csr_index;
   logic [31:0]     csr_data;

   top_k_select uut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // Shadow copy of the selection chain and registers.
   logic [31:0] kept_value [KCells];
   logic [15:0] kept_pos   [KCells];
   logic        kept_valid [KCells];
   logic [16:0] next_pos;
   logic        overflowed;
   logic [6:0]  shadow_keep;
   logic        shadow_largest;

   rsp_payload_type pending_picks[$];
   int errors;
   int items_sent;
   int rows_sent;
   int picks_seen;
   int idle_cycles;

   // Float bits to unsigned key in numeric order, -0 folded onto +0.
   function automatic logic [31:0] float_rank(logic [31:0] b);
      logic [31:0] t;
      t = (b[30:0] == 31'd0) ? 32'd0 : b;
      return t[31] ? ~t : (t | 32'h8000_0000);
   endfunction

   function automatic bit beats(logic [31:0] a, logic [31:0] b);
      return shadow_largest ? (float_rank(a) > float_rank(b))
                            : (float_rank(a) < float_rank(b));
   endfunction

   function automatic void clear_chain();
      for (int i = 0; i < KCells; i++) kept_valid[i] = 1'b0;
      next_pos   = '0;
      overflowed = 1'b0;
   endfunction

   // Insert one element; on a last element queue up the picks, best first.
   function automatic void select_element(logic [31:0] v, logic last);
      logic [15:0]     pos;
      int              p;
      int              k;
      int              n;
      rsp_payload_type r;
      if (next_pos >= RowLimit) begin
         overflowed = 1'b1;
         pos = 16'(RowLimit - 1);
      end else begin
         pos = next_pos[15:0];
         next_pos++;
      end
      p = 0;
      while (p < KCells && kept_valid[p] && !beats(v, kept_value[p])) p++;
      if (p < KCells) begin
         for (int j = KCells - 1; j > p; j--) begin
            kept_value[j] = kept_value[j-1];
            kept_pos[j]   = kept_pos[j-1];
            kept_valid[j] = kept_valid[j-1];
         end
         kept_value[p] = v;
         kept_pos[p]   = pos;
         kept_valid[p] = 1'b1;
      end
      if (!last) return;
      k = (shadow_keep == 0) ? 1 : (shadow_keep > KCells ? KCells : shadow_keep);
      n = 0;
      while (n < KCells && kept_valid[n]) n++;
      if (k < n) n = k;
      for (int j = 0; j < n; j++) begin
         r.value_out    = kept_value[j];
         r.index_out    = kept_pos[j];
         r.last_out     = (j == n - 1);
         r.row_overflow = overflowed;
         pending_picks.push_back(r);
      end
      clear_chain();
   endfunction

   // Result checker: every strobe must match the oldest pending pick.
   always @(posedge clock) begin
      rsp_payload_type e;
      if (!reset && rsp_strobe) begin
         picks_seen++;
         if (pending_picks.size() == 0) begin
            errors++;
            $display("%0t: unexpected result %h", $time, rsp_payload);
         end else begin
            e = pending_picks.pop_front();
            if (rsp_payload.value_out !== e.value_out) begin
               errors++;
               $display("%0t: value exp %h got %h", $time, e.value_out,
                        rsp_payload.value_out);
            end
            if (rsp_payload.index_out !== e.index_out) begin
               errors++;
               $display("%0t: index exp %0d got %0d", $time, e.index_out,
                        rsp_payload.index_out);
            end
            if (rsp_payload.last_out !== e.last_out) begin
               errors++;
               $display("%0t: last exp %b got %b", $time, e.last_out,
                        rsp_payload.last_out);
            end
            if (rsp_payload.row_overflow !== e.row_overflow) begin
               errors++;
               $display("%0t: overflow exp %b got %b", $time, e.row_overflow,
                        rsp_payload.row_overflow);
            end
         end
      end
   end

   // Watchdog: any transfer on any channel resets the idle count.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= Stall) begin
         $display("%0t: watchdog expired, %0d results pending", $time,
                  pending_picks.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Mostly back to back, some short gaps, rare long ones.
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   // All tasks enter and leave at a falling edge.
   task automatic send_element(logic [31:0] v, logic last);
      int g;
      g = gap_len();
      if (g > 0) begin
         start <= 1'b0;
         repeat (g) @(negedge clock);
      end
      start                <= 1'b1;
      req_payload.value_in <= v;
      req_payload.last_in  <= last;
      @(posedge clock);
      while (busy) @(posedge clock);
      select_element(v, last);
      items_sent++;
      if (last) rows_sent++;
      @(negedge clock);
   endtask

   task automatic go_quiet();
      start <= 1'b0;
      @(negedge clock);
   endtask

   // Wait out pending picks, then the chain's emission time, before a write.
   task automatic settle();
      start <= 1'b0;
      while (pending_picks.size() != 0) @(negedge clock);
      repeat (KCells + 4) @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [31:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= d;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_KEEP_COUNT) shadow_keep = d[6:0];
      else                       shadow_largest = d[0];
      @(negedge clock);
      csr_valid <= 1'b0;
      csr_data  <= $urandom;
      @(negedge clock);
   endtask

   // Random element, biased toward signed zeros, infinities and repeats.
   function automatic logic [31:0] pick_value();
      logic [31:0] specials [8];
      specials = '{32'h0000_0000, 32'h8000_0000, 32'h7f80_0000, 32'hff80_0000,
                   32'h3f80_0000, 32'hbf80_0000, 32'h0000_0001, 32'h7f7f_ffff};
      case ($urandom_range(0, 3))
         0:       return specials[$urandom_range(0, 7)];
         1:       return {1'($urandom_range(0, 1)), 8'd127, 19'd0,
                          4'($urandom_range(0, 7))};
         default: return $urandom;
      endcase
   endfunction

   task automatic send_row(int len);
      for (int i = 0; i < len; i++) send_element(pick_value(), i == len - 1);
   endtask

   // Extremes of the element fields, ties, signed zeros, single-item rows.
   task automatic test_directed();
      write_reg(CSR_KEEP_COUNT, 32'd4);
      send_element(32'h0000_0000, 1'b1);
      send_element(32'hffff_ffff, 1'b0);
      send_element(32'h8000_0000, 1'b0);
      send_element(32'h0000_0000, 1'b0);
      send_element(32'h7f80_0000, 1'b0);
      send_element(32'hff80_0000, 1'b1);
      send_element(32'h3f80_0000, 1'b0);   // equal values: lower index first
      send_element(32'h3f80_0000, 1'b0);
      send_element(32'h7fff_ffff, 1'b1);
      settle();
      write_reg(CSR_PICK_LARGEST, 32'd0);
      send_element(32'h8000_0000, 1'b0);
      send_element(32'h0000_0000, 1'b0);
      send_element(32'h0000_0001, 1'b0);
      send_element(32'h8000_0001, 1'b1);
      settle();
      write_reg(CSR_PICK_LARGEST, 32'hffff_fffe);
      write_reg(CSR_KEEP_COUNT, 32'd1);
      send_row(3);
      settle();
   endtask

   // keep_count at 0, 1, the chain size and above it; short rows under a big k.
   task automatic test_keep_extremes();
      int ks [5];
      ks = '{0, 1, 64, 65, 127};
      foreach (ks[i]) begin
         write_reg(CSR_KEEP_COUNT, {$urandom_range(0, 1) ? 25'h1ff_ffff : 25'd0, 7'(ks[i])});
         write_reg(CSR_PICK_LARGEST, $urandom);
         send_row(ks[i] > 1 ? 70 : 5);
         send_row(2);
         settle();
      end
   endtask

   // Registers rewritten while a row is half collected.
   task automatic test_mid_row_writes();
      write_reg(CSR_KEEP_COUNT, 32'd8);
      write_reg(CSR_PICK_LARGEST, 32'd1);
      for (int i = 0; i < 6; i++) send_element(pick_value(), 1'b0);
      settle();
      write_reg(CSR_PICK_LARGEST, 32'd0);
      write_reg(CSR_KEEP_COUNT, 32'd3);
      for (int i = 0; i < 6; i++) send_element(pick_value(), i == 5);
      settle();
   endtask

   // Random rows under random settings until the item budget is spent.
   task automatic test_random_rows();
      int target;
      int len;
      target = items_sent + 170;
      while (items_sent < target) begin
         if ($urandom_range(0, 2) == 0) begin
            settle();
            write_reg(CSR_KEEP_COUNT, $urandom_range(0, 3) == 0 ? $urandom
                                                                : $urandom_range(1, 16));
            write_reg(CSR_PICK_LARGEST, $urandom);
         end
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 90)
                                           : $urandom_range(1, 12);
         send_row(len);
      end
      settle();
   endtask

   initial begin
      errors      = 0;
      items_sent  = 0;
      rows_sent   = 0;
      picks_seen  = 0;
      reset       = 1'b1;
      start       = 1'b0;
      req_payload = '0;
      csr_valid   = 1'b0;
      csr_index   = CSR_KEEP_COUNT;
      csr_data    = '0;
      shadow_keep    = 7'd1;
      shadow_largest = 1'b1;
      clear_chain();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_keep_extremes();
      test_mid_row_writes();
      test_random_rows();
      go_quiet();

      $display("covered %0d elements in %0d rows, %0d results checked", items_sent,
               rows_sent, picks_seen);
      $display("k from 0 to 127, both orders, ties, signed zeros, mid-row writes");
      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

### filelist.f
hw/rtl/tks_pkg.sv
hw/rtl/tks_cell.sv
hw/rtl/top_k_select.sv
hw/rtl/top_k_select_checker.sv
dv/tb_top_k_select.sv
